// File: src/kwsc_pkg.sv
// Package for the keyword substitution cipher.
// Holds the shared types, constants and helper functions; depends on nothing.
package kwsc_pkg;

	// Alphabet and keyword limits
	localparam int LETTERS     = 26;
	localparam int LET_W       = $clog2(LETTERS);
	localparam int KEY_MAX_LEN = 26;
	localparam int SEEN_W      = $clog2(KEY_MAX_LEN + 1);

	localparam logic [7:0] LOWER_A = 8'd97;
	localparam logic [7:0] LOWER_Z = 8'd122;
	localparam logic [7:0] UPPER_A = 8'd65;
	localparam logic [7:0] UPPER_Z = 8'd90;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	localparam logic [LET_W-1:0] LAST_LETTER = LET_W'(LETTERS - 1);
	localparam logic [LET_W-1:0] LETTERS_L   = LET_W'(LETTERS);

	// Input item kinds, carried in s_tuser
	typedef enum logic [1:0] {
		ACT_KEY  = 2'd0,
		ACT_ENC  = 2'd1,
		ACT_DEC  = 2'd2,
		ACT_NONE = 2'd3
	} act_t;

	// Keyword builder states
	typedef enum logic {
		KS_RUN  = 1'b0,
		KS_FILL = 1'b1
	} kst_t;

	// Write ports of both table memories
	typedef struct packed {
		logic             we;
		logic [LET_W-1:0] fwd_addr;
		logic [LET_W-1:0] fwd_data;
		logic [LET_W-1:0] inv_addr;
		logic [LET_W-1:0] inv_data;
	} ram_wr_t;

	// Lowercase A-Z only
	function automatic logic [7:0] to_lower(input logic [7:0] b);
		if (b >= UPPER_A && b <= UPPER_Z) begin
			return b + CASE_OFFSET;
		end
		return b;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= LOWER_A && b <= LOWER_Z);
	endfunction

	function automatic logic [LET_W-1:0] letter_of(input logic [7:0] b);
		logic [7:0] d;
		d = b - LOWER_A;
		return d[LET_W-1:0];
	endfunction

endpackage

// File: src/kwsc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Self-contained; used for the forward and inverse substitution tables.
module kwsc_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 26
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/kwsc_key.sv
// Keyword builder: letter-used flags, fill and byte counters, and the fill walk.
// Drives the write ports of both table memories; uses kwsc_pkg.
module kwsc_key (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_acc,
	input  logic [7:0]          key_byte,
	input  logic                key_last,
	output logic                busy,
	output logic                table_ready,
	output kwsc_pkg::ram_wr_t   wr
);

	kwsc_pkg::kst_t st_q, st_d;

	logic [kwsc_pkg::LETTERS-1:0]  used_q, used_base;
	logic [kwsc_pkg::LET_W-1:0]    fill_q, fill_base, walk_q;
	logic [kwsc_pkg::SEEN_W-1:0]   seen_q, seen_base;
	logic                          ready_q, in_prog_q;

	logic [7:0]                    lo;
	logic [kwsc_pkg::LET_W-1:0]    letter;
	logic                          counted, place_key, place_walk, walk_done;

	// Keyword byte decode, with the new-keyword clear applied first
	always_comb begin
		lo        = kwsc_pkg::to_lower(key_byte);
		letter    = kwsc_pkg::letter_of(lo);
		used_base = in_prog_q ? used_q : '0;
		fill_base = in_prog_q ? fill_q : '0;
		seen_base = in_prog_q ? seen_q : '0;
		counted   = (seen_base < kwsc_pkg::SEEN_W'(kwsc_pkg::KEY_MAX_LEN));
		place_key = key_acc && counted && kwsc_pkg::is_letter(lo) &&
			!used_base[letter] && (fill_base < kwsc_pkg::LETTERS_L);
	end

	// Fill walk step: place the walked letter if still unused
	always_comb begin
		place_walk = (st_q == kwsc_pkg::KS_FILL) && !used_q[walk_q] &&
			(fill_q < kwsc_pkg::LETTERS_L);
		walk_done  = (st_q == kwsc_pkg::KS_FILL) && (walk_q == kwsc_pkg::LAST_LETTER);
	end

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			kwsc_pkg::KS_RUN: begin
				if (key_acc && key_last) begin
					st_d = kwsc_pkg::KS_FILL;
				end
			end
			kwsc_pkg::KS_FILL: begin
				if (walk_done) begin
					st_d = kwsc_pkg::KS_RUN;
				end
			end
			default: st_d = kwsc_pkg::KS_RUN;
		endcase
	end

	// Outputs: table writes
	always_comb begin
		wr = '0;
		case (st_q)
			kwsc_pkg::KS_RUN: begin
				wr.we       = place_key;
				wr.fwd_addr = fill_base;
				wr.fwd_data = letter;
				wr.inv_addr = letter;
				wr.inv_data = fill_base;
			end
			kwsc_pkg::KS_FILL: begin
				wr.we       = place_walk;
				wr.fwd_addr = fill_q;
				wr.fwd_data = walk_q;
				wr.inv_addr = walk_q;
				wr.inv_data = fill_q;
			end
			default: wr = '0;
		endcase
	end

	// Status, straight from registers
	assign busy        = (st_q == kwsc_pkg::KS_FILL);
	assign table_ready = ready_q;

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= kwsc_pkg::KS_RUN;
			used_q    <= '0;
			fill_q    <= '0;
			seen_q    <= '0;
			walk_q    <= '0;
			ready_q   <= 1'b0;
			in_prog_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (key_acc) begin
				in_prog_q <= 1'b1;
				ready_q   <= 1'b0;
				walk_q    <= '0;
				seen_q    <= counted ? seen_base + 1'b1 : seen_base;
				if (place_key) begin
					used_q         <= used_base | (kwsc_pkg::LETTERS'(1) << letter);
					fill_q         <= fill_base + 1'b1;
				end else begin
					used_q <= used_base;
					fill_q <= fill_base;
				end
			end else if (st_q == kwsc_pkg::KS_FILL) begin
				walk_q <= walk_q + 1'b1;
				if (place_walk) begin
					used_q[walk_q] <= 1'b1;
					fill_q         <= fill_q + 1'b1;
				end
				if (walk_done) begin
					ready_q   <= 1'b1;
					in_prog_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: src/kwsc_text.sv
// Text path: table read stage and output register for encrypt and decrypt bytes.
// Reads both table memories at the letter index; uses kwsc_pkg.
module kwsc_text (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       txt_acc,
	input  logic                       txt_dec,
	input  logic [7:0]                 txt_byte,
	input  logic                       table_ready,
	input  logic [kwsc_pkg::LET_W-1:0] fwd_rdata,
	input  logic [kwsc_pkg::LET_W-1:0] inv_rdata,
	output logic                       rd_en,
	output logic [kwsc_pkg::LET_W-1:0] rd_addr,
	output logic                       space,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,
	output logic [0:0]                 m_tuser
);

	logic                       v_s1, map_s1, inv_s1, nrdy_s1;
	logic [7:0]                 byte_s1;
	logic                       m_valid_q;
	logic [7:0]                 m_data_q;
	logic                       m_nrdy_q;

	logic [7:0]                 lo;
	logic                       let_in, out_free;
	logic [kwsc_pkg::LET_W-1:0] mapped, mapped_mod;
	logic [7:0]                 result;

	// Issue the table read on acceptance
	always_comb begin
		lo       = kwsc_pkg::to_lower(txt_byte);
		let_in   = kwsc_pkg::is_letter(lo);
		rd_en    = txt_acc;
		rd_addr  = let_in ? kwsc_pkg::letter_of(lo) : '0;
	end

	// Hold the read stage while the output register is full and not taken
	always_comb begin
		out_free = !m_valid_q || m_tready;
		space    = !v_s1 || out_free;
	end

	// Map the read letter back to a lowercase byte
	always_comb begin
		mapped     = inv_s1 ? inv_rdata : fwd_rdata;
		mapped_mod = (mapped >= kwsc_pkg::LETTERS_L) ? mapped - kwsc_pkg::LETTERS_L : mapped;
		result     = map_s1 ? kwsc_pkg::LOWER_A + 8'(mapped_mod) : byte_s1;
	end

	// Read stage valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			v_s1 <= txt_acc || (v_s1 && !out_free);
			if (out_free) begin
				m_valid_q <= v_s1;
			end
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (txt_acc) begin
			byte_s1 <= lo;
			map_s1  <= table_ready && let_in;
			inv_s1  <= txt_dec;
			nrdy_s1 <= !table_ready;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			m_data_q <= result;
			m_nrdy_q <= nrdy_s1;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_nrdy_q;

endmodule

// File: src/keyword_substitution_cipher.sv
// Top level of the keyword substitution cipher.
// Instantiates kwsc_key, kwsc_text and two kwsc_ram tables; uses kwsc_pkg.
//
//  Channel | Dir | Signals                                  | Content
//  s_      | in  | tvalid tready tdata[7:0] tuser[1:0] tlast | data_byte, action, key_end
//  m_      | out | tvalid tready tdata[7:0] tuser[0:0]       | out_byte, not_ready
//
// Keyword and text bytes are taken one per cycle while s_tready is high; text
// results pass the table read stage, then the output register.
// A keyword byte with tlast starts a walk over the alphabet that writes the
// unused letters into the tables; s_tready is low during it.
// Reset clears only the control state. Before a full fill, text bytes pass
// unmapped with not_ready set. A stalled output holds the read stage and then s_tready.
module keyword_substitution_cipher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic [1:0] s_tuser,  // [1:0] action
	input  logic       s_tlast,  // key_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic [0:0] m_tuser   // [0] not_ready
);

	kwsc_pkg::act_t            act;
	kwsc_pkg::ram_wr_t         wr;
	logic                      acc, key_acc, txt_acc, busy, table_ready, space, rd_en;
	logic [kwsc_pkg::LET_W-1:0] rd_addr, fwd_rdata, inv_rdata;

	// Decode the transfer
	always_comb begin
		act      = kwsc_pkg::act_t'(s_tuser);
		s_tready = !busy && space;
		acc      = s_tvalid && s_tready;
		key_acc  = acc && (act == kwsc_pkg::ACT_KEY);
		txt_acc  = acc && (act == kwsc_pkg::ACT_ENC || act == kwsc_pkg::ACT_DEC);
	end

	kwsc_key u_key (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_acc     (key_acc),
		.key_byte    (s_tdata),
		.key_last    (s_tlast),
		.busy        (busy),
		.table_ready (table_ready),
		.wr          (wr)
	);

	kwsc_ram #(
		.WIDTH (kwsc_pkg::LET_W),
		.DEPTH (kwsc_pkg::LETTERS)
	) u_fwd_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.fwd_addr),
		.wdata (wr.fwd_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (fwd_rdata)
	);

	kwsc_ram #(
		.WIDTH (kwsc_pkg::LET_W),
		.DEPTH (kwsc_pkg::LETTERS)
	) u_inv_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.inv_addr),
		.wdata (wr.inv_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (inv_rdata)
	);

	kwsc_text u_text (
		.clk         (clk),
		.arst_n      (arst_n),
		.txt_acc     (txt_acc),
		.txt_dec     (act == kwsc_pkg::ACT_DEC),
		.txt_byte    (s_tdata),
		.table_ready (table_ready),
		.fwd_rdata   (fwd_rdata),
		.inv_rdata   (inv_rdata),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.space       (space),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule
